// File: hdl/assert_macros.svh
// Assertion helpers for the RTL files; the core module includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// An antecedent that implies a consequent in the next cycle, checked in reset too.
`define ASSERT_NEXT_RAW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/tlfk_pkg.sv
`timescale 1ns / 1ps
package tlfk_pkg;

  localparam int ANGLE_BITS_DEF  = 16;
  localparam int LENGTH_BITS_DEF = 16;

  localparam int CORDIC_STEPS = 28;
  localparam int XW           = 33;   // CORDIC x/y, 2^30 scaled
  localparam int ZW           = 33;   // CORDIC residual angle
  localparam int Q15_W        = 16;
  localparam logic signed [XW-1:0] CORDIC_ONE = 33'sd652032874;

  localparam int XY_W   = 18;
  localparam int D_W    = 17;
  localparam int XY_MAX = 131071;
  localparam int XY_MIN = -131072;
  localparam int D_MAX  = 131071;

  localparam int SQRT_STEPS = 18;
  localparam int NW         = 36;

  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int SQRT_LAT   = SQRT_STEPS + 1;

  // Register indexes decoded from the address.
  localparam logic REG_FIRST_LEN  = 1'b0;
  localparam logic REG_SECOND_LEN = 1'b1;

  // Arctangent of 2^-i in units where 2^32 is one full turn.
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Round a 2^30 scaled value to Q1.15 and saturate.
  function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [XW-1:0] v);
    logic signed [XW:0] t;
    t = ((XW+1)'(v) + (XW+1)'(16384)) >>> 15;
    if (t > 32767) return 16'sh7fff;
    if (t < -32768) return 16'sh8000;
    return t[Q15_W-1:0];
  endfunction

endpackage

// File: hdl/tlfk_cordic.sv
`timescale 1ns / 1ps
module tlfk_cordic import tlfk_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ANGLE_BITS-1:0]   angle,
  output logic signed [Q15_W-1:0] cos_q15,
  output logic signed [Q15_W-1:0] sin_q15
);

  logic [31:0]          phase;
  logic [31:0]          phase_rnd;
  logic [1:0]           quad;
  logic [31:0]          rdiff;

  logic signed [XW-1:0] x_r [0:CORDIC_STEPS];
  logic signed [XW-1:0] y_r [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z_r [0:CORDIC_STEPS];
  logic [1:0]           q_r [0:CORDIC_STEPS];

  logic signed [XW-1:0] c_sel, s_sel;
  logic signed [Q15_W-1:0] cos_r, sin_r;

  // Split the phase into the nearest quarter turn and a signed residual.
  assign phase     = {angle, {(32-ANGLE_BITS){1'b0}}};
  assign phase_rnd = phase + 32'h2000_0000;
  assign quad      = phase_rnd[31:30];
  assign rdiff     = phase - {quad, 30'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_ONE;
      y_r[0] <= '0;
      z_r[0] <= ZW'($signed(rdiff));
      q_r[0] <= quad;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1] <= q_r[i];
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - $signed(ZW'(atan_turn(i)));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + $signed(ZW'(atan_turn(i)));
        end
      end
    end
  end

  always_comb begin
    case (q_r[CORDIC_STEPS])
      2'd0: begin
        c_sel = x_r[CORDIC_STEPS];
        s_sel = y_r[CORDIC_STEPS];
      end
      2'd1: begin
        c_sel = -y_r[CORDIC_STEPS];
        s_sel = x_r[CORDIC_STEPS];
      end
      2'd2: begin
        c_sel = -x_r[CORDIC_STEPS];
        s_sel = -y_r[CORDIC_STEPS];
      end
      default: begin
        c_sel = y_r[CORDIC_STEPS];
        s_sel = -x_r[CORDIC_STEPS];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= to_q15(c_sel);
      sin_r <= to_q15(s_sel);
    end
  end

  assign cos_q15 = cos_r;
  assign sin_q15 = sin_r;

endmodule

// File: hdl/tlfk_isqrt.sv
`timescale 1ns / 1ps
module tlfk_isqrt import tlfk_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [NW-1:0]  radicand,
  output logic [D_W-1:0] root
);

  logic [NW-1:0]  n_r [0:SQRT_STEPS];
  logic [NW-1:0]  r_r [0:SQRT_STEPS];
  logic [NW-1:0]  r_fin;
  logic [D_W-1:0] root_r;

  assign n_r[0] = radicand;
  assign r_r[0] = '0;

  // One result bit per stage, highest first.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_bit
    localparam logic [NW-1:0] BIT = NW'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [NW:0] trial;
    assign trial = {1'b0, r_r[k]} + {1'b0, BIT};
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, n_r[k]} >= trial) begin
          n_r[k+1] <= n_r[k] - trial[NW-1:0];
          r_r[k+1] <= (r_r[k] >> 1) + BIT;
        end else begin
          n_r[k+1] <= n_r[k];
          r_r[k+1] <= r_r[k] >> 1;
        end
      end
    end
  end

  // Round to nearest: the remainder exceeds the root past the half point.
  assign r_fin = r_r[SQRT_STEPS] + NW'(n_r[SQRT_STEPS] > r_r[SQRT_STEPS]);

  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= (r_fin > NW'(D_MAX)) ? D_W'(D_MAX) : r_fin[D_W-1:0];
    end
  end

  assign root = root_r;

endmodule

// File: hdl/two_link_forward_kinematics_core.sv
`timescale 1ns / 1ps
// An accepted item passes through the sine/cosine pipelines, then the multiply,
// round and square steps, then the square root, before its result appears.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous, active low; clears valid bits and sets both link lengths to 0.
module two_link_forward_kinematics_core import tlfk_pkg::*; #(
  parameter int ANGLE_BITS  = ANGLE_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ANGLE_BITS-1:0]  in_first_angle,
  input  logic [ANGLE_BITS-1:0]  in_second_angle,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [XY_W-1:0] out_end_x,
  output logic signed [XY_W-1:0] out_end_y,
  output logic [D_W-1:0]         out_reach_distance,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

`include "assert_macros.svh"

  // The registers hold the low LENGTH_BITS bits of the written data, at most 16.
  localparam int LEN_W    = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;
  localparam int PW       = LEN_W + Q15_W + 1;
  localparam int LAT      = CORDIC_LAT + 4 + SQRT_LAT;
  localparam int XY_DELAY = 2 + SQRT_LAT;

  logic en;

  // Configuration registers. Writes should arrive only while the pipeline is empty; the block does not enforce this.
  logic [LEN_W-1:0] len1_r, len2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len1_r <= '0;
      len2_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_FIRST_LEN:  len1_r <= pwdata[LEN_W-1:0];
        REG_SECOND_LEN: len2_r <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SECOND_LEN) ? 32'(len2_r) : 32'(len1_r);

  // The pipeline moves as one: it advances whenever the output register is free
  // or being emptied in this cycle. While a result waits, every stage and the
  // input hold their contents, so no item is dropped or repeated.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic vld_r [0:LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  assign out_valid = vld_r[LAT-1];

  // Sine and cosine of each absolute link angle.
  logic signed [Q15_W-1:0] c1, s1, c2, s2;

  tlfk_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_first (
    .clk     (clk),
    .en      (en),
    .angle   (in_first_angle),
    .cos_q15 (c1),
    .sin_q15 (s1)
  );

  tlfk_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_second (
    .clk     (clk),
    .en      (en),
    .angle   (in_second_angle),
    .cos_q15 (c2),
    .sin_q15 (s2)
  );

  // Link length times each trig term, one multiplier per product.
  logic signed [PW-1:0] px1_r, px2_r, py1_r, py2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r <= PW'($signed({1'b0, len1_r}) * c1);
      px2_r <= PW'($signed({1'b0, len2_r}) * c2);
      py1_r <= PW'($signed({1'b0, len1_r}) * s1);
      py2_r <= PW'($signed({1'b0, len2_r}) * s2);
    end
  end

  // Sum, round half up to whole length units and clamp to the output range.
  logic signed [PW:0]      xs, ys;
  logic signed [XY_W-1:0]  x_r, y_r;

  assign xs = ((PW+1)'(px1_r) + (PW+1)'(px2_r) + (PW+1)'(16384)) >>> 15;
  assign ys = ((PW+1)'(py1_r) + (PW+1)'(py2_r) + (PW+1)'(16384)) >>> 15;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= (xs > XY_MAX) ? XY_W'(XY_MAX) : (xs < XY_MIN) ? XY_W'(XY_MIN) : xs[XY_W-1:0];
      y_r <= (ys > XY_MAX) ? XY_W'(XY_MAX) : (ys < XY_MIN) ? XY_W'(XY_MIN) : ys[XY_W-1:0];
    end
  end

  // Squares, then their sum as the square root's radicand.
  logic signed [NW-1:0] sqx_r, sqy_r;
  logic [NW-1:0]        n_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= x_r * x_r;
      sqy_r <= y_r * y_r;
      n_r   <= NW'(sqx_r) + NW'(sqy_r);
    end
  end

  tlfk_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (n_r),
    .root     (out_reach_distance)
  );

  // Coordinates wait beside the square root so that they leave with it.
  logic signed [XY_W-1:0] xd_r [0:XY_DELAY-1];
  logic signed [XY_W-1:0] yd_r [0:XY_DELAY-1];

  always_ff @(posedge clk) begin
    if (en) begin
      xd_r[0] <= x_r;
      yd_r[0] <= y_r;
      for (int i = 1; i < XY_DELAY; i++) begin
        xd_r[i] <= xd_r[i-1];
        yd_r[i] <= yd_r[i-1];
      end
    end
  end

  assign out_end_x = xd_r[XY_DELAY-1];
  assign out_end_y = yd_r[XY_DELAY-1];

  `ASSERT_NEXT_RAW(a_reset_clears_out, !rst_n, !out_valid, "result valid right after reset")
  `ASSERT_IMPL(a_stall_only_when_full, !in_ready, out_valid, "input blocked with no result held")
  `ASSERT_IMPL(a_axis_distance, out_valid && (out_end_x == '0),
    (out_end_y[XY_W-1] ? -out_end_y : out_end_y) == $signed({1'b0, out_reach_distance}),
    "distance on the y axis differs from |y|")

endmodule
